/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
// Both sample on clk and are disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is never true at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/spts_pkg.sv */
`timescale 1ns / 1ps

package spts_pkg;

  localparam int DATA_W        = 32;
  localparam int EXP_W         = 8;
  localparam int POS_W         = 4;
  localparam int MAX_TERMS_DEF = 16;

  // Operation codes of an item
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_EVAL   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // One stored term
  typedef struct packed {
    logic [EXP_W-1:0]  e;
    logic [DATA_W-1:0] coef;
  } term_t;

endpackage

/* rtl/sorted_polynomial_term_store.sv */
`timescale 1ns / 1ps

// Sparse polynomial store: up to MAX_TERMS (exponent, coefficient) terms held in
// ascending exponent order in a single-port-read term RAM, with one shared 32x32
// multiplier for evaluation. Pulse start while busy is low to hand in an item;
// busy stays high until the result, which appears on ok/value/term_exponent/
// term_count for exactly one cycle with done high. There is no way to hold the
// result off, so capture it on done. The sequencer walks the RAM one entry at a
// time: insert and remove scan terms and then move terms; evaluate works through
// each stored term bit by bit of its exponent. Inserting onto an existing exponent
// adds the coefficient and succeeds even when the table is full. Arithmetic wraps
// mod 2^32.
`include "assert_macros.svh"

module sorted_polynomial_term_store #(
  parameter int MAX_TERMS = spts_pkg::MAX_TERMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         op,
  input  logic signed [spts_pkg::DATA_W-1:0] coefficient,
  input  logic [spts_pkg::EXP_W-1:0]         exponent,
  input  logic signed [spts_pkg::DATA_W-1:0] x_value,
  input  logic [spts_pkg::POS_W-1:0]         position,
  output logic                               done,
  output logic                               ok,
  output logic signed [spts_pkg::DATA_W-1:0] value,
  output logic [spts_pkg::EXP_W-1:0]         term_exponent,
  output logic [$clog2(MAX_TERMS+1)-1:0]     term_count
);
  import spts_pkg::*;

  localparam int AW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW   = $clog2(MAX_TERMS + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_SRD   = 16'h0002,
    S_SCMP  = 16'h0004,
    S_SHRD  = 16'h0008,
    S_SHWR  = 16'h0010,
    S_PUT   = 16'h0020,
    S_ERD   = 16'h0040,
    S_ELD   = 16'h0080,
    S_EPOW  = 16'h0100,
    S_EMWB  = 16'h0200,
    S_ESQ   = 16'h0400,
    S_ESWB  = 16'h0800,
    S_ECOEF = 16'h1000,
    S_ESUM  = 16'h2000,
    S_RRD   = 16'h4000,
    S_RDATA = 16'h8000
  } state_t;

  state_t              state;
  op_t                 op_r;
  logic [DATA_W-1:0]   coef_in;
  logic [DATA_W-1:0]   x_in;
  logic [EXP_W-1:0]    e_in;
  logic [POS_W-1:0]    pos_in;
  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       k;
  logic [CW-1:0]       k_dec;
  logic [CW-1:0]       k_inc;
  logic [DATA_W-1:0]   acc;
  logic [DATA_W-1:0]   base;
  logic [DATA_W-1:0]   cterm;
  logic [DATA_W-1:0]   sum;
  logic [EXP_W-1:0]    ebits;
  logic                full;
  logic                is_ins;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;
  term_t               mem_wdata;
  term_t               mem_rdata;
  logic [DATA_W-1:0]   mul_a;
  logic [DATA_W-1:0]   mul_b;
  logic [DATA_W-1:0]   prod;
  logic [CMPW-1:0]     pos_ext;
  logic [CMPW-1:0]     cnt_ext;
  logic [CMPW-1:0]     rd_sel;

  spts_mem #(.DEPTH(MAX_TERMS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  spts_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign busy       = (state != S_IDLE);
  assign term_count = count;
  assign full       = (count == CW'(MAX_TERMS));
  assign is_ins     = (op_r == OP_INSERT);
  assign k_dec      = k - 1'b1;
  assign k_inc      = k + 1'b1;

  // Clamp the read position to the last stored term
  assign pos_ext = CMPW'(pos_in);
  assign cnt_ext = CMPW'(count);
  assign rd_sel  = (pos_ext >= cnt_ext) ? (cnt_ext - 1'b1) : pos_ext;

  // Steer the RAM ports and the shared multiplier
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = '{e: e_in, coef: coef_in};
    mem_raddr = idx[AW-1:0];
    mul_a     = acc;
    mul_b     = base;
    case (state)
      S_SCMP: begin
        if (is_ins && mem_rdata.e == e_in) begin
          mem_we    = 1'b1;
          mem_wdata = '{e: e_in, coef: mem_rdata.coef + coef_in};
        end
      end
      S_SHRD: begin
        mem_raddr = is_ins ? k_dec[AW-1:0] : k_inc[AW-1:0];
      end
      S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = k[AW-1:0];
        mem_wdata = mem_rdata;
      end
      S_PUT: begin
        mem_we = 1'b1;
      end
      S_RRD: begin
        mem_raddr = rd_sel[AW-1:0];
      end
      S_ESQ: begin
        mul_a = base;
      end
      S_ECOEF: begin
        mul_a = cterm;
        mul_b = acc;
      end
      default: begin
      end
    endcase
  end

  // Sequence one item through search, shift, power, sum and read steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r    <= op_t'(op);
            coef_in <= coefficient;
            x_in    <= x_value;
            e_in    <= exponent;
            pos_in  <= position;
            idx     <= '0;
            sum     <= '0;
            case (op_t'(op))
              OP_INSERT, OP_REMOVE: state <= S_SRD;
              OP_EVAL:              state <= S_ERD;
              default:              state <= S_RRD;
            endcase
          end
        end
        S_SRD: begin
          if (idx == count) begin
            if (is_ins && !full) begin
              k     <= count;
              state <= S_SHRD;
            end else begin
              state         <= S_IDLE;
              done          <= 1'b1;
              ok            <= 1'b0;
              value         <= '0;
              term_exponent <= '0;
            end
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (mem_rdata.e < e_in) begin
            idx   <= idx + 1'b1;
            state <= S_SRD;
          end else if (mem_rdata.e == e_in) begin
            if (is_ins) begin
              // coefficient merged by the write port this cycle
              state         <= S_IDLE;
              done          <= 1'b1;
              ok            <= 1'b1;
              value         <= '0;
              term_exponent <= '0;
            end else begin
              k     <= idx;
              state <= S_SHRD;
            end
          end else if (is_ins && !full) begin
            k     <= count;
            state <= S_SHRD;
          end else begin
            state         <= S_IDLE;
            done          <= 1'b1;
            ok            <= 1'b0;
            value         <= '0;
            term_exponent <= '0;
          end
        end
        S_SHRD: begin
          if (is_ins) begin
            state <= (k == idx) ? S_PUT : S_SHWR;
          end else if (k_inc == count) begin
            count         <= count - 1'b1;
            state         <= S_IDLE;
            done          <= 1'b1;
            ok            <= 1'b1;
            value         <= '0;
            term_exponent <= '0;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          k     <= is_ins ? k_dec : k_inc;
          state <= S_SHRD;
        end
        S_PUT: begin
          count         <= count + 1'b1;
          state         <= S_IDLE;
          done          <= 1'b1;
          ok            <= 1'b1;
          value         <= '0;
          term_exponent <= '0;
        end
        S_ERD: begin
          if (idx == count) begin
            state         <= S_IDLE;
            done          <= 1'b1;
            ok            <= (count != '0);
            value         <= sum;
            term_exponent <= '0;
          end else begin
            state <= S_ELD;
          end
        end
        S_ELD: begin
          acc   <= DATA_W'(1);
          base  <= x_in;
          ebits <= mem_rdata.e;
          cterm <= mem_rdata.coef;
          state <= S_EPOW;
        end
        S_EPOW: begin
          if (ebits == '0) begin
            state <= S_ECOEF;
          end else if (ebits[0]) begin
            state <= S_EMWB;
          end else begin
            state <= S_ESQ;
          end
        end
        S_EMWB: begin
          acc   <= prod;
          state <= S_ESQ;
        end
        S_ESQ: begin
          state <= S_ESWB;
        end
        S_ESWB: begin
          base  <= prod;
          ebits <= ebits >> 1;
          state <= S_EPOW;
        end
        S_ECOEF: begin
          state <= S_ESUM;
        end
        S_ESUM: begin
          sum   <= sum + prod;
          idx   <= idx + 1'b1;
          state <= S_ERD;
        end
        S_RRD: begin
          if (count == '0) begin
            state         <= S_IDLE;
            done          <= 1'b1;
            ok            <= 1'b0;
            value         <= '0;
            term_exponent <= '0;
          end else begin
            state <= S_RDATA;
          end
        end
        S_RDATA: begin
          state         <= S_IDLE;
          done          <= 1'b1;
          ok            <= 1'b1;
          value         <= mem_rdata.coef;
          term_exponent <= mem_rdata.e;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_done_idle, done |-> !busy, "result shown while still busy")
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted item did not start")
  `ASSERT_CLK(a_done_after_work, done |-> $past(busy), "result without an item in work")
  `ASSERT_CLK(a_count_on_done, (term_count != $past(term_count)) |-> done, "count moved mid item")
  `ASSERT_NEVER(a_count_bound, term_count > CW'(MAX_TERMS), "term count above capacity")

endmodule

/* rtl/spts_mem.sv */
`timescale 1ns / 1ps

module spts_mem #(
  parameter int DEPTH = spts_pkg::MAX_TERMS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  spts_pkg::term_t wdata,
  input  logic [AW-1:0]   raddr,
  output spts_pkg::term_t rdata
);
  import spts_pkg::*;

  term_t mem [DEPTH];

  // Write one term
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/spts_mul.sv */
`timescale 1ns / 1ps

module spts_mul (
  input  logic                        clk,
  input  logic [spts_pkg::DATA_W-1:0] a,
  input  logic [spts_pkg::DATA_W-1:0] b,
  output logic [spts_pkg::DATA_W-1:0] p
);
  import spts_pkg::*;

  // Keep the low word of the product, registered
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import spts_pkg::*;

  localparam int  TERM_SLOTS  = 16;
  localparam int  ITEM_TARGET = 800;
  localparam int  TAIL_CYCLES = 64;
  localparam int  REPORT_MAX  = 10;
  // worst case: every item an evaluate of a full table of 8-bit exponents
  // plus the longest sender gap, taken several times over
  localparam longint CYCLE_LIMIT = 2_500_000;

  typedef struct {
    bit        ok;
    bit [31:0] value;
    bit [7:0]  term_exp;
    bit [4:0]  count;
  } term_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        op;
  logic signed [31:0] coefficient;
  logic [7:0]        exponent;
  logic signed [31:0] x_value;
  logic [3:0]        position;
  logic              done;
  logic              ok;
  logic signed [31:0] value;
  logic [7:0]        term_exponent;
  logic [4:0]        term_count;

  // shadow copy of the term table
  bit [7:0]  shadow_exp [TERM_SLOTS];
  bit [31:0] shadow_coef[TERM_SLOTS];
  int        shadow_count;

  term_result_t awaited_results[$];
  int           items_sent;
  int           results_checked;
  int           mismatch_count;
  int           refused_count;
  int           peak_fill;
  int           op_tally[4];
  longint       cycle_count;

  sorted_polynomial_term_store i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .coefficient   (coefficient),
    .exponent      (exponent),
    .x_value       (x_value),
    .position      (position),
    .done          (done),
    .ok            (ok),
    .value         (value),
    .term_exponent (term_exponent),
    .term_count    (term_count)
  );

  always #5 clk = ~clk;

  // raise x to e with wraparound, square and multiply
  function automatic bit [31:0] wrap_power(bit [31:0] base, bit [7:0] e);
    bit [31:0] acc;
    acc = 32'd1;
    while (e != 8'd0) begin
      if (e[0]) acc = acc * base;
      base = base * base;
      e    = e >> 1;
    end
    return acc;
  endfunction

  // apply one item to the shadow table and return the result it should give
  function automatic term_result_t apply_term_op(op_t o, bit [31:0] c, bit [7:0] e,
                                                 bit [31:0] xv, bit [3:0] p);
    term_result_t r;
    int           i;
    int           k;
    int           sel;
    r = '{ok: 1'b0, value: 32'd0, term_exp: 8'd0, count: 5'd0};
    i = 0;
    case (o)
      OP_INSERT: begin
        while (i < shadow_count && shadow_exp[i] < e) i++;
        if (i < shadow_count && shadow_exp[i] == e) begin
          shadow_coef[i] = shadow_coef[i] + c;
          r.ok = 1'b1;
        end else if (shadow_count < TERM_SLOTS) begin
          for (k = shadow_count; k > i; k--) begin
            shadow_exp[k]  = shadow_exp[k-1];
            shadow_coef[k] = shadow_coef[k-1];
          end
          shadow_exp[i]  = e;
          shadow_coef[i] = c;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        while (i < shadow_count && shadow_exp[i] < e) i++;
        if (i < shadow_count && shadow_exp[i] == e) begin
          for (k = i; k + 1 < shadow_count; k++) begin
            shadow_exp[k]  = shadow_exp[k+1];
            shadow_coef[k] = shadow_coef[k+1];
          end
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      OP_EVAL: begin
        if (shadow_count > 0) begin
          for (k = 0; k < shadow_count; k++)
            r.value = r.value + shadow_coef[k] * wrap_power(xv, shadow_exp[k]);
          r.ok = 1'b1;
        end
      end
      default: begin
        if (shadow_count > 0) begin
          sel = (int'(p) >= shadow_count) ? shadow_count - 1 : int'(p);
          r.value    = shadow_coef[sel];
          r.term_exp = shadow_exp[sel];
          r.ok       = 1'b1;
        end
      end
    endcase
    r.count = shadow_count[4:0];
    return r;
  endfunction

  // hand one item to the block and record what it should return
  task automatic send_item(op_t o, bit [31:0] c, bit [7:0] e, bit [31:0] xv, bit [3:0] p);
    op          <= o;
    coefficient <= c;
    exponent    <= e;
    x_value     <= xv;
    position    <= p;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    awaited_results.push_back(apply_term_op(o, c, e, xv, p));
    items_sent++;
    op_tally[o]++;
    if (shadow_count > peak_fill) peak_fill = shadow_count;
  endtask

  // drop start for a random stretch: mostly none or short, now and then long
  task automatic sender_gap();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 60)      len = 0;
    else if (pick < 90) len = $urandom_range(1, 3);
    else                len = $urandom_range(10, 60);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // hold the sender until every outstanding result is back
  task automatic drain_results();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // empty table, extremes, coefficient merge with wrap, zero terms, full table
  task automatic test_directed();
    int n;
    send_item(OP_REMOVE, 32'd0, 8'd0, 32'd0, 4'd0);
    send_item(OP_EVAL, 32'd0, 8'd0, 32'd5, 4'd0);
    send_item(OP_READ, 32'd0, 8'd0, 32'd0, 4'd15);
    send_item(OP_INSERT, 32'h7fff_ffff, 8'd255, 32'd0, 4'd0);
    send_item(OP_INSERT, 32'h8000_0000, 8'd0, 32'd0, 4'd0);
    send_item(OP_INSERT, 32'd1, 8'd255, 32'd0, 4'd0);
    send_item(OP_INSERT, 32'd5, 8'd128, 32'd0, 4'd0);
    send_item(OP_INSERT, -32'sd5, 8'd128, 32'd0, 4'd0);
    for (n = 1; n <= 13; n++) begin
      send_item(OP_INSERT, $urandom, n[7:0], $urandom, 4'($urandom_range(0, 15)));
      sender_gap();
    end
    // table is full now: new exponent refused, existing one still merges
    send_item(OP_INSERT, 32'd9, 8'd200, 32'd0, 4'd0);
    send_item(OP_INSERT, 32'd1, 8'd0, 32'd0, 4'd0);
    send_item(OP_EVAL, 32'd0, 8'd0, 32'h8000_0000, 4'd0);
    send_item(OP_EVAL, 32'd0, 8'd0, 32'hffff_ffff, 4'd0);
    send_item(OP_READ, 32'd0, 8'd0, 32'd0, 4'd15);
    send_item(OP_REMOVE, 32'd0, 8'd77, 32'd0, 4'd0);
    send_item(OP_REMOVE, 32'd0, 8'd255, 32'd0, 4'd0);
    send_item(OP_READ, 32'd0, 8'd0, 32'd0, 4'd15);
    drain_results();
  endtask

  // random items in phases that grow, churn and shrink the table
  task automatic test_random();
    int        n;
    int        phase;
    int        pick;
    op_t       o;
    bit [31:0] c;
    bit [7:0]  e;
    bit [31:0] xv;
    bit [3:0]  p;
    bit [31:0] edge_vals[6];
    edge_vals = '{32'd0, 32'd1, 32'hffff_ffff, 32'd2, 32'h8000_0000, 32'h7fff_ffff};
    for (n = 0; n < ITEM_TARGET; n++) begin
      phase = (n / 100) % 4;
      pick  = $urandom_range(0, 99);
      case (phase)
        0:       o = (pick < 55) ? OP_INSERT : (pick < 65) ? OP_REMOVE :
                     (pick < 80) ? OP_EVAL : OP_READ;
        2:       o = (pick < 10) ? OP_INSERT : (pick < 65) ? OP_REMOVE :
                     (pick < 80) ? OP_EVAL : OP_READ;
        default: o = (pick < 30) ? OP_INSERT : (pick < 55) ? OP_REMOVE :
                     (pick < 80) ? OP_EVAL : OP_READ;
      endcase
      // exponents: often an existing term, else a small pool or the full range
      pick = $urandom_range(0, 99);
      if (shadow_count > 0 && ((o == OP_REMOVE && pick < 70) || (o == OP_INSERT && pick < 30)))
        e = shadow_exp[$urandom_range(0, shadow_count - 1)];
      else if ($urandom_range(0, 1) == 0)
        e = 8'($urandom_range(0, 20));
      else
        e = 8'($urandom);
      c  = ($urandom_range(0, 9) == 0) ? edge_vals[$urandom_range(0, 5)] : $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 20)      xv = edge_vals[$urandom_range(0, 5)];
      else if (pick < 50) xv = 32'($urandom_range(0, 14)) - 32'd7;
      else                xv = $urandom;
      p = 4'($urandom_range(0, 15));
      send_item(o, c, e, xv, p);
      if (n == ITEM_TARGET / 2) drain_results();
      // every fifth stretch of 50 items runs back to back
      else if ((n / 50) % 5 != 4) sender_gap();
    end
    start <= 1'b0;
  endtask

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    term_result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("ERROR: result with nothing pending: ok=%0b value=%h exp=%0d count=%0d",
                   ok, value, term_exponent, term_count);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (!ok) refused_count++;
        if (ok !== want.ok || value !== want.value || term_exponent !== want.term_exp ||
            term_count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("ERROR: result %0d: expected ok=%0b value=%h exp=%0d count=%0d, got ok=%0b value=%h exp=%0d count=%0d",
                     results_checked, want.ok, want.value, want.term_exp, want.count,
                     ok, value, term_exponent, term_count);
        end
      end
    end
  end

  // stop a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL sorted_polynomial_term_store");
      $finish;
    end
  end

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    op           <= OP_INSERT;
    coefficient  <= '0;
    exponent     <= '0;
    x_value      <= '0;
    position     <= '0;
    shadow_count  = 0;
    items_sent    = 0;
    results_checked = 0;
    mismatch_count  = 0;
    refused_count   = 0;
    peak_fill       = 0;
    op_tally        = '{0, 0, 0, 0};
    cycle_count     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random();

    // wait out the last results, then watch for stray strobes
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (awaited_results.size() != 0) mismatch_count++;
    $display("Covered %0d items: %0d insert, %0d remove, %0d evaluate, %0d read.",
             items_sent, op_tally[OP_INSERT], op_tally[OP_REMOVE],
             op_tally[OP_EVAL], op_tally[OP_READ]);
    $display("Checked %0d results (%0d refused), peak table fill %0d, %0d mismatches.",
             results_checked, refused_count, peak_fill, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS sorted_polynomial_term_store");
    end else begin
      $display("FAIL sorted_polynomial_term_store");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/spts_pkg.sv
rtl/spts_mem.sv
rtl/spts_mul.sv
rtl/sorted_polynomial_term_store.sv
bench/tb.sv
